/* rtl/rprop_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RProp package
// Shared types, opcodes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package rprop_pkg;

  localparam int unsigned DefParamCount = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 63;

  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_SET_BEST = 3'd1,
    OP_GRAD     = 3'd2,
    OP_REPORT   = 3'd3,
    OP_READ     = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    CFG_STEP_INIT  = 3'd0,
    CFG_STEP_MIN   = 3'd1,
    CFG_STEP_MAX   = 3'd2,
    CFG_SHRINK     = 3'd3,
    CFG_GROW       = 3'd4,
    CFG_STOP_NORM  = 3'd5,
    CFG_STOP_HALV  = 3'd6,
    CFG_ITER_LIMIT = 3'd7
  } cfg_idx_e;

  // Command passed from the front part to the back part.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  index;
    logic        in_range;
    logic [31:0] data;
    logic        finite;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        improved;
    logic        stop;
  } res_t;

endpackage : rprop_pkg
`default_nettype wire

/* rtl/rprop_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RProp channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rprop_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [5:0]  param_index;
  logic [31:0] data_value;
  logic        value_finite;
  logic        last_element;
  modport source (output valid, opcode, param_index, data_value, value_finite,
                  last_element, input ready);
  modport sink (input valid, opcode, param_index, data_value, value_finite,
                last_element, output ready);
endinterface

interface rprop_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        improved;
  logic        stop;
  modport source (output valid, result_value, improved, stop, input ready);
  modport sink (input valid, result_value, improved, stop, output ready);
endinterface
`default_nettype wire

/* rtl/rprop_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RProp front
// Accepts items, checks the index and queues commands in a two-entry FIFO.
// ----------------------------------------------------------------------------
module rprop_front
  import rprop_pkg::*;
#(
  parameter int unsigned ParamCount = DefParamCount
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  rprop_in_if.sink in_if,
  output cmd_t cmd_o,
  output logic cmd_valid_o,
  input  wire  cmd_ready_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_in;

  assign in_if.ready = (cnt_q != 2'd2);
  assign push = in_if.valid && in_if.ready;
  assign pop  = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = fifo_q[rd_ptr_q];

  always_comb begin
    cmd_in.opcode   = in_if.opcode;
    cmd_in.index    = in_if.param_index;
    cmd_in.in_range = ({26'd0, in_if.param_index} < ParamCount);
    cmd_in.data     = in_if.data_value;
    cmd_in.finite   = in_if.value_finite;
    cmd_in.last     = in_if.last_element;
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule : rprop_front
`default_nettype wire

/* rtl/rprop_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RProp back
// Executes commands against the parameter stores through a sequencer.
// ----------------------------------------------------------------------------
module rprop_back
  import rprop_pkg::*;
#(
  parameter int unsigned ParamCount = DefParamCount,
  localparam int unsigned IdxW = (ParamCount > 1) ? $clog2(ParamCount) : 1
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cmd_t        cmd_i,
  input  wire         cmd_valid_i,
  output logic        cmd_ready_o,
  input  wire  [30:0] step_init_i,
  input  wire  [30:0] step_min_i,
  input  wire  [30:0] step_max_i,
  input  wire  [15:0] shrink_i,
  input  wire  [15:0] grow_i,
  input  wire  [62:0] stop_norm_i,
  input  wire  [4:0]  stop_halv_i,
  input  wire  [15:0] iter_limit_i,
  rprop_out_if.source out_if
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_MUL  = 5'b00100,
    S_WB   = 5'b01000,
    S_COPY = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] cur_mem [ParamCount];
  logic [31:0] best_mem [ParamCount];
  logic [30:0] step_mem [ParamCount];
  logic [1:0]  psign_q [ParamCount];

  logic [63:0] norm_q;
  logic [5:0]  halv_q;
  logic [31:0] best_lik_q;
  logic [15:0] iter_q;

  cmd_t        cmd_q;
  logic [IdxW-1:0] idx;
  logic [31:0] cur_rd_q;
  logic [30:0] step_rd_q;
  logic [31:0] mag_q;
  logic        neg_q;
  logic [47:0] prod_q;
  logic [1:0]  rel_q; // 1 same sign, 2 sign change
  logic [IdxW-1:0] copy_q;
  logic [31:0] copy_rd_q;
  logic        copy_rv_q;
  logic [IdxW:0] copy_cnt_q;

  logic        res_v_q;
  res_t        res_q;

  assign idx = cmd_q.index[IdxW-1:0];
  // A new command may start in the cycle the pending result is taken.
  assign cmd_ready_o = (state_q == S_IDLE) && (!res_v_q || out_if.ready);
  assign out_if.valid = res_v_q;
  assign out_if.result_value = res_q.result_value;
  assign out_if.improved = res_q.improved;
  assign out_if.stop = res_q.stop;

  // Gradient magnitude and sign at the read stage.
  logic [31:0] dmag;
  logic [31:0] smag;
  logic [1:0]  csign;
  always_comb begin
    dmag = cmd_q.data[31] ? (~cmd_q.data + 32'd1) : cmd_q.data;
    smag = (halv_q > 6'd31) ? 32'd0 : (dmag >> halv_q[4:0]);
    csign = (smag == 32'd0) ? 2'b00 : (cmd_q.data[31] ? 2'b11 : 2'b01);
  end

  // Write-back arithmetic.
  logic [35:0] scaled;
  logic [30:0] nstep;
  logic [1:0]  nsign;
  logic [31:0] fmag;
  logic [33:0] sum;
  logic [31:0] npar;
  logic [63:0] sq, nacc;
  logic [64:0] accsum;
  always_comb begin
    scaled = prod_q[47:12];
    nstep  = step_rd_q;
    nsign  = neg_q ? 2'b11 : ((mag_q == 32'd0) ? 2'b00 : 2'b01);
    fmag   = mag_q;
    if (rel_q == 2'd1) begin
      nstep = (scaled > 36'h07FFFFFFF) ? 31'h7FFFFFFF : scaled[30:0];
      if (nstep > step_max_i) nstep = step_max_i;
    end else if (rel_q == 2'd2) begin
      nstep = (scaled > 36'h07FFFFFFF) ? 31'h7FFFFFFF : scaled[30:0];
      if (nstep < step_min_i) nstep = step_min_i;
      nsign = 2'b00;
      fmag  = 32'd0;
    end
    if (nsign == 2'b01) begin
      sum = {{2{cur_rd_q[31]}}, cur_rd_q} + {3'd0, nstep};
    end else if (nsign == 2'b11) begin
      sum = {{2{cur_rd_q[31]}}, cur_rd_q} - {3'd0, nstep};
    end else begin
      sum = {{2{cur_rd_q[31]}}, cur_rd_q};
    end
    if (!sum[33] && sum[32:31] != 2'b00) npar = 32'h7FFFFFFF;
    else if (sum[33] && sum[32:31] != 2'b11) npar = 32'h80000000;
    else npar = sum[31:0];
    sq = fmag * fmag;
    accsum = {1'b0, norm_q} + {1'b0, sq};
    nacc = accsum[64] ? 64'hFFFFFFFFFFFFFFFF : accsum[63:0];
  end

  logic [15:0] iter_n;
  logic [5:0]  halv_n;
  logic        better;
  assign iter_n = (iter_q != 16'hFFFF) ? iter_q + 16'd1 : iter_q;
  assign halv_n = (halv_q != 6'd63) ? halv_q + 6'd1 : halv_q;
  assign better = cmd_q.finite && ($signed(cmd_q.data) > $signed(best_lik_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_valid_i && cmd_ready_o) state_d = S_RD;
      S_RD: begin
        if (cmd_q.opcode == OP_GRAD && cmd_q.in_range) state_d = S_MUL;
        else if (cmd_q.opcode == OP_REPORT && better) state_d = S_COPY;
        else state_d = S_IDLE;
      end
      S_MUL: state_d = S_WB;
      S_WB: state_d = S_IDLE;
      S_COPY: if (copy_cnt_q == IdxW'(0) + (IdxW+1)'(ParamCount)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      res_v_q    <= 1'b0;
      norm_q     <= 64'd0;
      halv_q     <= 6'd0;
      best_lik_q <= 32'h80000000;
      iter_q     <= 16'd0;
      for (int i = 0; i < ParamCount; i++) psign_q[i] <= 2'b00;
    end else begin
      state_q <= state_d;
      if (res_v_q && out_if.ready) res_v_q <= 1'b0;
      unique case (state_q)
        S_RD: begin
          if (cmd_q.opcode == OP_LOAD && cmd_q.in_range) psign_q[idx] <= 2'b00;
          if (cmd_q.opcode == OP_SET_BEST) begin
            best_lik_q <= cmd_q.data;
            halv_q <= 6'd0;
            iter_q <= 16'd0;
            norm_q <= 64'd0;
          end
          if (cmd_q.opcode == OP_REPORT) begin
            iter_q <= iter_n;
            if (better) best_lik_q <= cmd_q.data;
            else halv_q <= halv_n;
          end
          if (!(cmd_q.opcode == OP_GRAD && cmd_q.in_range) &&
              !(cmd_q.opcode == OP_REPORT && better)) res_v_q <= 1'b1;
        end
        S_WB: begin
          psign_q[idx] <= nsign;
          norm_q <= cmd_q.last ? 64'd0 : nacc;
          res_v_q <= 1'b1;
        end
        S_COPY: if (state_d == S_IDLE) res_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath and memories.
  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
    cur_rd_q   <= cur_mem[idx];
    step_rd_q  <= step_mem[idx];
    copy_rd_q  <= cur_mem[copy_q];
    unique case (state_q)
      S_RD: begin
        copy_q     <= '0;
        copy_cnt_q <= '0;
        copy_rv_q  <= 1'b0;
        mag_q <= smag;
        neg_q <= (csign == 2'b11);
        if (csign == 2'b00 || psign_q[idx] == 2'b00) rel_q <= 2'd0;
        else if (csign == psign_q[idx]) rel_q <= 2'd1;
        else rel_q <= 2'd2;
        res_q.improved <= (cmd_q.opcode == OP_REPORT) && better;
        res_q.stop <= (cmd_q.opcode == OP_REPORT) &&
                      (({10'd0, iter_n} >= {10'd0, iter_limit_i}) ||
                       (!better && (halv_n > {1'b0, stop_halv_i})));
        unique case (cmd_q.opcode)
          OP_LOAD: begin
            if (cmd_q.in_range) begin
              cur_mem[idx]  <= cmd_q.data;
              best_mem[idx] <= cmd_q.data;
              step_mem[idx] <= step_init_i;
            end
            res_q.result_value <= cmd_q.in_range ? cmd_q.data : 32'd0;
          end
          OP_SET_BEST: res_q.result_value <= cmd_q.data;
          OP_REPORT: res_q.result_value <= better ? cmd_q.data : best_lik_q;
          OP_READ: res_q.result_value <= cmd_q.in_range ? best_mem[idx] : 32'd0;
          // Gradients are answered at write back; unknown opcodes answer zero.
          default: res_q.result_value <= 32'd0;
        endcase
      end
      S_MUL: begin
        // The read registers were loaded at the end of S_RD.
        prod_q <= {17'd0, step_rd_q} *
                  {32'd0, ((rel_q == 2'd1) ? grow_i : shrink_i)};
      end
      S_WB: begin
        step_mem[idx] <= nstep;
        cur_mem[idx]  <= npar;
        res_q.result_value <= npar;
        res_q.stop <= cmd_q.last && ({1'b0, nacc} < {2'b0, stop_norm_i});
      end
      S_COPY: begin
        copy_q    <= (copy_q == IdxW'(ParamCount - 1)) ? '0 : copy_q + IdxW'(1);
        copy_rv_q <= 1'b1;
        copy_cnt_q <= copy_cnt_q + (IdxW+1)'(copy_rv_q);
        if (copy_rv_q) best_mem[copy_q - IdxW'(1) + ((copy_q == '0) ?
                                IdxW'(ParamCount) : IdxW'(0))] <= copy_rd_q;
      end
      default: ;
    endcase
  end

endmodule : rprop_back
`default_nettype wire

/* rtl/rprop_parameter_update_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RProp parameter update core
// RProp-minus step engine for a Q16.16 parameter vector.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_if (opcode, param_index, data_value, value_finite,
// last_element) and each item yields exactly one result on out_if
// (result_value, improved, stop). Both channels use valid/ready.
// The front part accepts items into a two-entry command queue, so input
// keeps flowing while the back part works or the receiver stalls.
// The back part runs one item at a time: loads, best-likelihood sets,
// reads, non-improving reports and ignored items pass through accept and
// read; a gradient element passes through accept, read, multiply of step
// by factor and write back. An improving likelihood report copies the
// whole current vector into the best store one entry per cycle. A load
// result is registered in the read state after the queue and the command
// register; the next item starts in the cycle the result is taken.
// The result sits in an output register; while it is not taken the back
// part holds and the queue fills, then in_if.ready drops.
// Reset clears the queue, signs, counters and the best likelihood and
// restores register defaults; parameter stores are undefined until loaded.
// Configuration registers should be written only while no item is in flight.
// ----------------------------------------------------------------------------
module rprop_parameter_update_core
  import rprop_pkg::*;
#(
  parameter int unsigned ParamCount = DefParamCount
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire [CfgIdxW-1:0]  cfg_idx_i,
  input  wire [CfgDataW-1:0] cfg_data_i,
  rprop_in_if.sink           in_if,
  rprop_out_if.source        out_if
);

  logic [30:0] step_init_q, step_min_q, step_max_q;
  logic [15:0] shrink_q, grow_q, iter_limit_q;
  logic [62:0] stop_norm_q;
  logic [4:0]  stop_halv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_init_q  <= 31'd6554;
      step_min_q   <= 31'd0;
      step_max_q   <= 31'd3276800;
      shrink_q     <= 16'd2048;
      grow_q       <= 16'd4915;
      stop_norm_q  <= 63'd0;
      stop_halv_q  <= 5'd31;
      iter_limit_q <= 16'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STEP_INIT:  step_init_q  <= cfg_data_i[30:0];
        CFG_STEP_MIN:   step_min_q   <= cfg_data_i[30:0];
        CFG_STEP_MAX:   step_max_q   <= cfg_data_i[30:0];
        CFG_SHRINK:     shrink_q     <= cfg_data_i[15:0];
        CFG_GROW:       grow_q       <= cfg_data_i[15:0];
        CFG_STOP_NORM:  stop_norm_q  <= cfg_data_i;
        CFG_STOP_HALV:  stop_halv_q  <= cfg_data_i[4:0];
        CFG_ITER_LIMIT: iter_limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  rprop_front #(.ParamCount(ParamCount)) u_front (
    .clk_i, .rst_ni, .in_if,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  rprop_back #(.ParamCount(ParamCount)) u_back (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .step_init_i(step_init_q), .step_min_i(step_min_q), .step_max_i(step_max_q),
    .shrink_i(shrink_q), .grow_i(grow_q), .stop_norm_i(stop_norm_q),
    .stop_halv_i(stop_halv_q), .iter_limit_i(iter_limit_q),
    .out_if
  );

endmodule : rprop_parameter_update_core
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RProp parameter update core testbench
// Drives load, best-likelihood, gradient, report and read-best items through
// the valid/ready channels with random gaps and stalls, predicts every result
// with a behavioral copy of the step engine and compares field by field.
// ----------------------------------------------------------------------------
module testbench;
  import rprop_pkg::*;

  localparam int unsigned NParams = DefParamCount;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  index;
    logic [31:0] data;
    logic        finite;
    logic        last;
  } step_item_t;

  typedef struct {
    step_item_t item;
    bit         has_expect;
    res_t       expect_res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rprop_in_if  in_if ();
  rprop_out_if out_if ();

  rprop_parameter_update_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Predictor state: register copies and the engine's own stores.
  logic [30:0] reg_step_init, reg_step_min, reg_step_max;
  logic [15:0] reg_shrink, reg_grow, reg_iter_limit;
  logic [62:0] reg_stop_norm;
  logic [4:0]  reg_halv_shift;

  logic signed [31:0] cur_param [NParams];
  logic signed [31:0] best_param [NParams];
  logic [31:0]        step_size [NParams];
  int                 prev_sign [NParams];
  bit                 loaded [NParams];
  logic [63:0]        norm_acc;
  int unsigned        halvings;
  logic signed [31:0] best_lik;
  int unsigned        iters;

  res_t        pending_results [$];
  int unsigned mismatches;
  int unsigned accepted_in, accepted_out;
  int unsigned stop_seen, improved_seen, grad_count;
  int unsigned idle_cycles;
  bit          long_stall;
  bit          stim_done;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH result %0d %s: got %h want %h", accepted_out, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [62:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_STEP_INIT:  reg_step_init = value[30:0];
      CFG_STEP_MIN:   reg_step_min = value[30:0];
      CFG_STEP_MAX:   reg_step_max = value[30:0];
      CFG_SHRINK:     reg_shrink = value[15:0];
      CFG_GROW:       reg_grow = value[15:0];
      CFG_STOP_NORM:  reg_stop_norm = value;
      CFG_STOP_HALV:  reg_halv_shift = value[4:0];
      CFG_ITER_LIMIT: reg_iter_limit = value[15:0];
      default: ;
    endcase
  endtask

  // Step times a Q4.12 factor, truncated and saturated to 31 bits.
  function automatic logic [63:0] scaled_step(input logic [63:0] stp, input logic [15:0] f);
    logic [63:0] t;
    t = (stp * f) >> 12;
    return (t > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : t;
  endfunction

  // Works out the result of one item and advances the predicted state.
  function automatic res_t rprop_predict(input step_item_t it);
    res_t r;
    logic signed [63:0] dv, moved;
    logic [63:0] mag, stp, sq;
    int cur, prod;
    bit in_rng;
    r = '0;
    dv = $signed(it.data);
    in_rng = it.index < NParams;
    case (it.opcode)
      OP_LOAD: if (in_rng) begin
        cur_param[it.index] = it.data;
        best_param[it.index] = it.data;
        step_size[it.index] = {1'b0, reg_step_init};
        prev_sign[it.index] = 0;
        loaded[it.index] = 1'b1;
        r.result_value = it.data;
      end
      OP_SET_BEST: begin
        best_lik = it.data;
        halvings = 0;
        iters = 0;
        norm_acc = '0;
        r.result_value = it.data;
      end
      OP_GRAD: if (in_rng) begin
        mag = (dv < 0) ? -dv : dv;
        mag = mag >> halvings;
        cur = (mag == 0) ? 0 : ((dv < 0) ? -1 : 1);
        prod = cur * prev_sign[it.index];
        stp = step_size[it.index];
        if (prod > 0) begin
          stp = scaled_step(stp, reg_grow);
          if (stp > reg_step_max) stp = reg_step_max;
        end else if (prod < 0) begin
          stp = scaled_step(stp, reg_shrink);
          if (stp < reg_step_min) stp = reg_step_min;
          cur = 0;
          mag = 0;
        end
        step_size[it.index] = stp[31:0];
        moved = 64'($signed(cur_param[it.index])) + cur * $signed(stp);
        if (moved > 64'sh7FFF_FFFF) moved = 64'sh7FFF_FFFF;
        else if (moved < -64'sh8000_0000) moved = -64'sh8000_0000;
        cur_param[it.index] = moved[31:0];
        prev_sign[it.index] = cur;
        sq = mag * mag;
        norm_acc = (norm_acc > ~sq) ? '1 : norm_acc + sq;
        r.result_value = cur_param[it.index];
        if (it.last) begin
          r.stop = norm_acc < {1'b0, reg_stop_norm};
          norm_acc = '0;
        end
      end
      OP_REPORT: begin
        if (iters < 16'hFFFF) iters++;
        if (it.finite && $signed(it.data) > best_lik) begin
          best_lik = it.data;
          for (int i = 0; i < NParams; i++) best_param[i] = cur_param[i];
          r.improved = 1'b1;
        end else begin
          if (halvings < 63) halvings++;
          if (halvings > reg_halv_shift) r.stop = 1'b1;
        end
        if (iters >= reg_iter_limit) r.stop = 1'b1;
        r.result_value = best_lik;
      end
      OP_READ: if (in_rng) r.result_value = best_param[it.index];
      default: ;
    endcase
    return r;
  endfunction

  // Sender gaps: mostly none or short, now and then long.
  task automatic sender_gap();
    int unsigned n;
    case ($urandom_range(9))
      0, 1, 2: n = $urandom_range(3, 1);
      3:       n = $urandom_range(30, 8);
      default: n = 0;
    endcase
    if (n != 0) in_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Offers one item and waits for the handshake; valid stays up for a
  // following item sent without a gap.
  task automatic send_item(input step_item_t it, input bit has_exp, input res_t exp_r);
    res_t pred;
    sender_gap();
    in_if.valid        <= 1'b1;
    in_if.opcode       <= it.opcode;
    in_if.param_index  <= it.index;
    in_if.data_value   <= it.data;
    in_if.value_finite <= it.finite;
    in_if.last_element <= it.last;
    do @(posedge clk_i); while (!in_if.ready);
    // Prediction happens at acceptance, so the queue order is the item order.
    pred = rprop_predict(it);
    if (has_exp) begin
      if (pred.result_value !== exp_r.result_value)
        report_mismatch("table row value", pred.result_value, exp_r.result_value);
      if (pred.improved !== exp_r.improved)
        report_mismatch("table row improved", 32'(pred.improved), 32'(exp_r.improved));
      if (pred.stop !== exp_r.stop)
        report_mismatch("table row stop", 32'(pred.stop), 32'(exp_r.stop));
    end
    pending_results.push_back(pred);
    if (it.opcode == OP_GRAD) grad_count++;
  endtask

  // Waits until every expected result has arrived and the engine has settled.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Picks a loaded index, or index 0 when 64 random tries find none.
  function automatic logic [5:0] pick_loaded();
    int unsigned tries;
    logic [5:0] i;
    for (tries = 0; tries < 64; tries++) begin
      i = $urandom_range(NParams - 1);
      if (loaded[i]) return i;
    end
    return 6'd0;
  endfunction

  function automatic logic [31:0] rand_grad();
    case ($urandom_range(5))
      0: return $urandom;
      1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(400000)) - 200000);
    endcase
  endfunction

  // One well-formed iteration: gradients over loaded entries, then a report and, one time in four, a best read.
  task automatic run_iteration();
    int unsigned n;
    step_item_t it;
    res_t none;
    none = '0;
    n = $urandom_range(NParams, 1);
    for (int k = 0; k < n; k++) begin
      it = '{OP_GRAD, pick_loaded(), rand_grad(), 1'($urandom), k == n - 1};
      send_item(it, 0, none);
    end
    it = '{OP_REPORT, 6'($urandom), best_lik + 32'($signed($urandom_range(2000)) - 1000),
           $urandom_range(7) != 0, 1'($urandom)};
    send_item(it, 0, none);
    if ($urandom_range(3) == 0) begin
      it = '{OP_READ, pick_loaded(), $urandom, 1'($urandom), 1'($urandom)};
      send_item(it, 0, none);
    end
  endtask

  // A random item of any kind, out-of-range indexes and unknown opcodes too.
  task automatic send_noise();
    step_item_t it;
    res_t none;
    none = '0;
    it = '{3'($urandom), 6'($urandom), $urandom, 1'($urandom), 1'($urandom)};
    if (it.index < NParams && !loaded[it.index] && it.opcode inside {OP_GRAD, OP_READ})
      it.opcode = OP_LOAD;
    send_item(it, 0, none);
  endtask

  task automatic load_all();
    step_item_t it;
    res_t none;
    none = '0;
    for (int i = 0; i < NParams; i++) begin
      it = '{OP_LOAD, 6'(i), 32'($signed($urandom_range(2000000)) - 1000000), 1'b0, 1'b0};
      send_item(it, 0, none);
    end
  endtask

  // Directed table; expectations typed in only where obvious.
  stim_row_t directed [] = '{
    '{'{OP_SET_BEST, 6'd0, 32'h8000_0000, 1'b1, 1'b0}, 1, '{32'h8000_0000, 1'b0, 1'b0}},
    '{'{OP_LOAD, 6'd0, 32'h7FFF_FFFF, 1'b0, 1'b0}, 1, '{32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{'{OP_LOAD, 6'd1, 32'h8000_0000, 1'b0, 1'b0}, 1, '{32'h8000_0000, 1'b0, 1'b0}},
    '{'{OP_LOAD, 6'd2, 32'h0000_0000, 1'b0, 1'b0}, 1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{'{OP_LOAD, 6'd15, 32'h0001_0000, 1'b1, 1'b1}, 1, '{32'h0001_0000, 1'b0, 1'b0}},
    '{'{OP_LOAD, 6'd63, 32'h1234_5678, 1'b0, 1'b0}, 1, '{32'h0, 1'b0, 1'b0}},
    '{'{OP_GRAD, 6'd0, 32'h7FFF_FFFF, 1'b0, 1'b0}, 1, '{32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{'{OP_GRAD, 6'd1, 32'h8000_0000, 1'b0, 1'b0}, 1, '{32'h8000_0000, 1'b0, 1'b0}},
    '{'{OP_GRAD, 6'd2, 32'h0000_0000, 1'b0, 1'b0}, 0, '0},
    '{'{OP_GRAD, 6'd15, 32'h0000_0100, 1'b0, 1'b0}, 0, '0},
    '{'{OP_GRAD, 6'd15, 32'h0000_0200, 1'b0, 1'b0}, 0, '0},
    '{'{OP_GRAD, 6'd15, 32'hFFFF_0000, 1'b0, 1'b0}, 0, '0},
    '{'{OP_GRAD, 6'd40, 32'h0000_1000, 1'b0, 1'b1}, 1, '{32'h0, 1'b0, 1'b0}},
    '{'{OP_GRAD, 6'd2, 32'h0000_0010, 1'b0, 1'b1}, 0, '0},
    '{'{OP_REPORT, 6'd0, 32'h0000_0000, 1'b0, 1'b0}, 0, '0},
    '{'{OP_REPORT, 6'd0, 32'h0000_0000, 1'b1, 1'b0}, 0, '0},
    '{'{OP_READ, 6'd2, 32'h0, 1'b0, 1'b0}, 0, '0},
    '{'{OP_READ, 6'd50, 32'h0, 1'b0, 1'b0}, 1, '{32'h0, 1'b0, 1'b0}},
    '{'{OP_REPORT, 6'd63, 32'h7FFF_FFFF, 1'b1, 1'b1}, 0, '0},
    '{'{OP_READ, 6'd15, 32'hFFFF_FFFF, 1'b1, 1'b1}, 0, '0},
    '{'{3'd5, 6'd0, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1, '{32'h0, 1'b0, 1'b0}},
    '{'{3'd6, 6'd3, 32'h1, 1'b0, 1'b0}, 1, '{32'h0, 1'b0, 1'b0}},
    '{'{3'd7, 6'd63, 32'h0, 1'b1, 1'b0}, 1, '{32'h0, 1'b0, 1'b0}}
  };

  // Receiver: random ready with one long hold-off so the input queue fills.
  initial begin
    int unsigned n;
    out_if.ready <= 1'b0;
    long_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!long_stall && accepted_in > 200) begin
        long_stall = 1'b1;
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      case ($urandom_range(9))
        0, 1: n = $urandom_range(3, 1);
        2:    n = $urandom_range(25, 6);
        default: n = 0;
      endcase
      if (n != 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Result checker and handshake counters; sampled at the edge.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && in_if.valid && in_if.ready) accepted_in <= accepted_in + 1;
    if (rst_ni && out_if.valid && out_if.ready) begin
      accepted_out <= accepted_out + 1;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_if.result_value, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.result_value !== want.result_value)
          report_mismatch("result_value", out_if.result_value, want.result_value);
        if (out_if.improved !== want.improved)
          report_mismatch("improved", 32'(out_if.improved), 32'(want.improved));
        if (out_if.stop !== want.stop)
          report_mismatch("stop", 32'(out_if.stop), 32'(want.stop));
        if (out_if.stop === 1'b1) stop_seen++;
        if (out_if.improved === 1'b1) improved_seen++;
      end
    end
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Timeout with %0d results outstanding", pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    res_t none;
    none = '0;
    mismatches = 0;
    accepted_in = 0;
    accepted_out = 0;
    stop_seen = 0;
    improved_seen = 0;
    grad_count = 0;
    idle_cycles = 0;
    stim_done = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.opcode = '0;
    in_if.param_index = '0;
    in_if.data_value = '0;
    in_if.value_finite = 1'b0;
    in_if.last_element = 1'b0;
    reg_step_init = 31'd6554;
    reg_step_min = '0;
    reg_step_max = 31'd3276800;
    reg_shrink = 16'd2048;
    reg_grow = 16'd4915;
    reg_stop_norm = '0;
    reg_halv_shift = 5'd31;
    reg_iter_limit = 16'd100;
    for (int i = 0; i < NParams; i++) begin
      cur_param[i] = '0;
      best_param[i] = '0;
      step_size[i] = '0;
      prev_sign[i] = 0;
      loaded[i] = 1'b0;
    end
    norm_acc = '0;
    halvings = 0;
    best_lik = 32'h8000_0000;
    iters = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset settings.
    foreach (directed[r])
      send_item(directed[r].item, directed[r].has_expect, directed[r].expect_res);
    drain();

    // Random phases, each with its own register setting; the first and last
    // use the extremes of every register.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_STEP_INIT, 63'h7FFF_FFFF);
          write_reg(CFG_STEP_MIN, 63'h7FFF_FFFF);
          write_reg(CFG_STEP_MAX, 63'h7FFF_FFFF);
          write_reg(CFG_SHRINK, 63'hFFFF);
          write_reg(CFG_GROW, 63'hFFFF);
          write_reg(CFG_STOP_NORM, 63'h7FFF_FFFF_FFFF_FFFF);
          write_reg(CFG_STOP_HALV, 63'd0);
          write_reg(CFG_ITER_LIMIT, 63'd0);
        end
        5: begin
          write_reg(CFG_STEP_INIT, 63'd0);
          write_reg(CFG_STEP_MIN, 63'd0);
          write_reg(CFG_STEP_MAX, 63'd0);
          write_reg(CFG_SHRINK, 63'd0);
          write_reg(CFG_GROW, 63'd0);
          write_reg(CFG_STOP_NORM, 63'd0);
          write_reg(CFG_STOP_HALV, 63'd31);
          write_reg(CFG_ITER_LIMIT, 63'hFFFF);
        end
        default: begin
          write_reg(CFG_STEP_INIT, $urandom_range(200000, 1));
          write_reg(CFG_STEP_MIN, $urandom_range(500));
          write_reg(CFG_STEP_MAX, $urandom_range(5000000, 1000));
          write_reg(CFG_SHRINK, $urandom_range(4095));
          write_reg(CFG_GROW, $urandom_range(8192, 4096));
          write_reg(CFG_STOP_NORM, {$urandom, $urandom} >> $urandom_range(63, 1));
          write_reg(CFG_STOP_HALV, $urandom_range(31));
          write_reg(CFG_ITER_LIMIT, $urandom_range(40, 1));
        end
      endcase
      load_all();
      send_item('{OP_SET_BEST, 6'($urandom), 32'($signed($urandom_range(4000)) - 2000),
                  1'($urandom), 1'($urandom)}, 0, none);
      while (accepted_in < 25 + (ph + 1) * 205) begin
        if ($urandom_range(9) < 8) run_iteration();
        else send_noise();
        if ($urandom_range(20) == 0)
          send_item('{OP_SET_BEST, 6'($urandom), $urandom, 1'($urandom), 1'($urandom)},
                    0, none);
      end
      drain();
    end
    stim_done = 1;

    $display("Covered %0d items, %0d gradient elements, over 7 register settings.",
             accepted_in, grad_count);
    $display("Saw %0d improving reports and %0d stop flags.", improved_seen, stop_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
